### rtl/bmld_pkg.sv
package bmld_pkg;

  localparam int CFG_W            = 16;
  localparam int CFG_IDX_W        = 3;
  localparam int DEF_TICK_BITS    = 32;
  localparam int DEF_HOLD_BITS    = 16;
  localparam int ARM_LEAD         = 20;
  localparam int HOLD_HEADROOM    = 100;
  localparam logic [1:0] TOGGLE_COUNT = 2'd3;

  localparam logic [CFG_W-1:0] RST_DEBOUNCE      = 16'd2;
  localparam logic [CFG_W-1:0] RST_CLICK_MIN     = 16'd1;
  localparam logic [CFG_W-1:0] RST_CLICK_MAX     = 16'd25;
  localparam logic [CFG_W-1:0] RST_CLICK_WINDOW  = 16'd75;
  localparam logic [CFG_W-1:0] RST_LONG_PRESS    = 16'd300;
  localparam logic [CFG_W-1:0] RST_STARTUP_IGN   = 16'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE     = 3'd0,
    CFG_CLICK_MIN    = 3'd1,
    CFG_CLICK_MAX    = 3'd2,
    CFG_CLICK_WINDOW = 3'd3,
    CFG_LONG_PRESS   = 3'd4,
    CFG_STARTUP_IGN  = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CLICK        = 3'd1,
    EV_TOGGLE       = 3'd2,
    EV_ARMED        = 3'd3,
    EV_CANCEL       = 3'd4,
    EV_FACTORY      = 3'd5,
    EV_LONG_CLEAR   = 3'd6,
    EV_WINDOW_CLEAR = 3'd7
  } ev_code_t;

  typedef struct packed {
    logic [CFG_W-1:0] settle_ticks;
    logic [CFG_W-1:0] tap_min_ticks;
    logic [CFG_W-1:0] tap_max_ticks;
    logic [CFG_W-1:0] click_window_ticks;
    logic [CFG_W-1:0] long_press_ticks;
    logic [CFG_W-1:0] startup_ignore_ticks;
  } cfg_t;

  typedef struct packed {
    logic             wr;
    logic [CFG_W-1:0] value;
  } ign_load_t;

  typedef struct packed {
    ev_code_t   event_res;
    logic [1:0] click_number;
    logic       config_mode;
    logic       indicator_on;
    logic       clean_level;
  } result_t;

endpackage

### rtl/bmld_cfg.sv
module bmld_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [bmld_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [bmld_pkg::CFG_W-1:0]     wr_data,
  output bmld_pkg::cfg_t                 cfg,
  output bmld_pkg::ign_load_t            ign_load
);
  import bmld_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.settle_ticks         <= RST_DEBOUNCE;
      cfg.tap_min_ticks        <= RST_CLICK_MIN;
      cfg.tap_max_ticks        <= RST_CLICK_MAX;
      cfg.click_window_ticks   <= RST_CLICK_WINDOW;
      cfg.long_press_ticks     <= RST_LONG_PRESS;
      cfg.startup_ignore_ticks <= RST_STARTUP_IGN;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_DEBOUNCE:     cfg.settle_ticks         <= wr_data;
        CFG_CLICK_MIN:    cfg.tap_min_ticks        <= wr_data;
        CFG_CLICK_MAX:    cfg.tap_max_ticks        <= wr_data;
        CFG_CLICK_WINDOW: cfg.click_window_ticks   <= wr_data;
        CFG_LONG_PRESS:   cfg.long_press_ticks     <= wr_data;
        CFG_STARTUP_IGN:  cfg.startup_ignore_ticks <= wr_data;
        default: begin
        end
      endcase
    end
  end

  // a startup-ignore write also reloads a running ignore period when no sample steps the core
  assign ign_load.wr    = wr_en && (wr_index == CFG_STARTUP_IGN);
  assign ign_load.value = wr_data;

endmodule

### rtl/bmld_core.sv
module bmld_core #(
  parameter int TICK_BITS = bmld_pkg::DEF_TICK_BITS,
  parameter int HOLD_BITS = bmld_pkg::DEF_HOLD_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  bmld_pkg::cfg_t      cfg,
  input  bmld_pkg::ign_load_t ign_load,
  input  logic                step,
  input  logic                raw,
  output bmld_pkg::result_t   res
);
  import bmld_pkg::*;

  localparam int HB = HOLD_BITS + 1;
  localparam int CW = (HB > CFG_W + 1) ? HB : CFG_W + 1;

  logic [CFG_W-1:0]     ignore_left, ignore_left_next;
  logic                 debounced, debounced_next;
  logic [CFG_W-1:0]     stable_run, stable_run_next;
  logic [HB-1:0]        hold_ticks, hold_ticks_next;
  logic                 armed, armed_next;
  logic                 previous_level, previous_level_next;
  logic [1:0]           clicks, clicks_next;
  logic [TICK_BITS-1:0] last_click_tick, last_click_tick_next;
  logic [TICK_BITS-1:0] tick_count, tick_count_next;
  logic                 mode_flag, mode_flag_next;
  logic                 indicator, indicator_next;

  logic [CW-1:0]        hold_w, hold_inc_w, lp_w, cap_w, thr_w, min_w, max_w;
  logic [HB-1:0]        hold_inc;
  logic [TICK_BITS-1:0] window_w, gap;
  logic [1:0]           clicks_base, clicks_inc;
  logic                 factory;
  ev_code_t             ev;
  logic [1:0]           num;

  assign lp_w     = CW'(cfg.long_press_ticks);
  assign cap_w    = lp_w + CW'(HOLD_HEADROOM);
  assign thr_w    = (lp_w >= CW'(ARM_LEAD)) ? lp_w - CW'(ARM_LEAD) : '0;
  assign min_w    = CW'(cfg.tap_min_ticks);
  assign max_w    = CW'(cfg.tap_max_ticks);
  assign window_w = TICK_BITS'(cfg.click_window_ticks);
  assign hold_w   = CW'(hold_ticks);
  assign hold_inc = ((hold_w < cap_w) && !(&hold_ticks)) ? hold_ticks + 1'b1 : hold_ticks;
  assign hold_inc_w = CW'(hold_inc);
  assign gap      = tick_count + TICK_BITS'(1) - last_click_tick;

  always_comb begin
    ignore_left_next     = ignore_left;
    debounced_next       = debounced;
    stable_run_next      = stable_run;
    hold_ticks_next      = hold_ticks;
    armed_next           = armed;
    previous_level_next  = previous_level;
    clicks_next          = clicks;
    last_click_tick_next = last_click_tick;
    tick_count_next      = tick_count;
    mode_flag_next       = mode_flag;
    indicator_next       = indicator;
    clicks_base          = clicks;
    clicks_inc           = clicks + 2'd1;
    factory              = 1'b0;
    ev                   = EV_NONE;
    num                  = 2'd0;

    if (ignore_left != '0) begin
      ignore_left_next = ignore_left - 1'b1;
    end else begin
      tick_count_next = tick_count + 1'b1;

      // debounce
      if (raw == debounced) begin
        stable_run_next = '0;
      end else if ({1'b0, stable_run} + 1'b1 >= {1'b0, cfg.settle_ticks}) begin
        debounced_next  = raw;
        stable_run_next = '0;
      end else begin
        stable_run_next = stable_run + 1'b1;
      end

      if (!debounced_next) begin
        hold_ticks_next = hold_inc;
        if (!armed && hold_inc_w >= thr_w && hold_inc_w < lp_w) begin
          armed_next     = 1'b1;
          clicks_next    = 2'd0;
          indicator_next = 1'b1;
          ev             = EV_ARMED;
        end
        if (hold_inc_w >= lp_w) begin
          factory = 1'b1;
        end
      end else begin
        if (armed) begin
          indicator_next = 1'b0;
          ev             = EV_CANCEL;
        end
        if (!previous_level && !armed && hold_w >= min_w && hold_w <= max_w) begin
          if (clicks != 2'd0 && gap > window_w) begin
            clicks_base = 2'd0;
          end
          clicks_inc           = clicks_base + 2'd1;
          last_click_tick_next = tick_count_next;
          ev                   = EV_CLICK;
          num                  = clicks_inc;
          if (clicks_inc == TOGGLE_COUNT) begin
            clicks_next    = 2'd0;
            mode_flag_next = !mode_flag;
            indicator_next = !mode_flag;
            ev             = EV_TOGGLE;
          end else begin
            clicks_next = clicks_inc;
          end
        end else if (!previous_level && !armed && hold_w > max_w) begin
          if (clicks != 2'd0) begin
            clicks_next = 2'd0;
            ev          = EV_LONG_CLEAR;
          end
        end
        hold_ticks_next = '0;
        armed_next      = 1'b0;
      end

      previous_level_next = debounced_next;

      if (clicks_next != 2'd0 && debounced_next &&
          (tick_count_next - last_click_tick_next) > window_w) begin
        clicks_next = 2'd0;
        if (ev == EV_NONE) begin
          ev = EV_WINDOW_CLEAR;
        end
      end

      if (factory) begin
        ignore_left_next     = cfg.startup_ignore_ticks;
        debounced_next       = 1'b1;
        stable_run_next      = '0;
        hold_ticks_next      = '0;
        armed_next           = 1'b0;
        previous_level_next  = 1'b1;
        clicks_next          = 2'd0;
        last_click_tick_next = '0;
        tick_count_next      = '0;
        mode_flag_next       = 1'b0;
        indicator_next       = 1'b0;
        ev                   = EV_FACTORY;
        num                  = 2'd0;
      end
    end
  end

  assign res.event_res    = ev;
  assign res.click_number = num;
  assign res.config_mode  = mode_flag_next;
  assign res.indicator_on = indicator_next;
  assign res.clean_level  = debounced_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_left     <= RST_STARTUP_IGN;
      debounced       <= 1'b1;
      stable_run      <= '0;
      hold_ticks      <= '0;
      armed           <= 1'b0;
      previous_level  <= 1'b1;
      clicks          <= 2'd0;
      last_click_tick <= '0;
      tick_count      <= '0;
      mode_flag       <= 1'b0;
      indicator       <= 1'b0;
    end else if (step) begin
      ignore_left     <= ignore_left_next;
      debounced       <= debounced_next;
      stable_run      <= stable_run_next;
      hold_ticks      <= hold_ticks_next;
      armed           <= armed_next;
      previous_level  <= previous_level_next;
      clicks          <= clicks_next;
      last_click_tick <= last_click_tick_next;
      tick_count      <= tick_count_next;
      mode_flag       <= mode_flag_next;
      indicator       <= indicator_next;
    end else if (ign_load.wr && ignore_left != '0) begin
      ignore_left <= ign_load.value;
    end
  end

`ifndef SYNTHESIS
  a_armed_lit: assert property (@(posedge clk) disable iff (rst) armed |-> indicator)
    else $error("armed without indicator");
  a_armed_pressed: assert property (@(posedge clk) disable iff (rst) armed |-> !debounced)
    else $error("armed while released");
  a_clicks_range: assert property (@(posedge clk) disable iff (rst) clicks != TOGGLE_COUNT)
    else $error("click count reached toggle count");
  a_ignore_tick: assert property (@(posedge clk) disable iff (rst)
    (ignore_left != '0) |-> (tick_count == '0))
    else $error("tick counter moved during ignore period");
`endif

endmodule

### rtl/button_multiclick_longpress_detector.sv
// Debounced button detector for multi-click and long press. Each input beat is
// one raw active-low pin sample taken at the poll tick, and each one gives
// exactly one result beat: an event code, the click number, the mode flag,
// the indicator drive and the clean level after that tick. The block takes one
// beat per clock unless the output side stalls; a sample passes an input
// register, the state update of the tracking core and a result register, and
// its result is held until the output side takes it. Configuration writes are
// taken at any time through their own channel but belong to idle periods; a
// write of the startup ignore length also reloads a running ignore period
// unless a sample steps the core in the same cycle.
module button_multiclick_longpress_detector #(
  parameter int TICK_BITS = bmld_pkg::DEF_TICK_BITS,
  parameter int HOLD_BITS = bmld_pkg::DEF_HOLD_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           pin_sample,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [2:0]                     event_res,
  output logic [1:0]                     click_number,
  output logic                           config_mode,
  output logic                           indicator_on,
  output logic                           clean_level,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bmld_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bmld_pkg::CFG_W-1:0]     cfg_data
);
  import bmld_pkg::*;

  cfg_t      cfg;
  ign_load_t ign_load;
  result_t   step_res;
  result_t   out_res;
  logic      in_v;
  logic      in_raw;
  logic      out_free;
  logic      fire;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign in_ready  = !in_v || out_free;
  assign fire      = in_v && out_free;

  bmld_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .ign_load (ign_load)
  );

  bmld_core #(
    .TICK_BITS (TICK_BITS),
    .HOLD_BITS (HOLD_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .ign_load (ign_load),
    .step     (fire),
    .raw      (in_raw),
    .res      (step_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        in_v <= in_valid;
      end
      if (out_free) begin
        out_valid <= in_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_raw <= pin_sample;
    end
    if (fire) begin
      out_res <= step_res;
    end
  end

  assign event_res    = out_res.event_res;
  assign click_number = out_res.click_number;
  assign config_mode  = out_res.config_mode;
  assign indicator_on = out_res.indicator_on;
  assign clean_level  = out_res.clean_level;

endmodule
